/* src/aaac_pkg.sv */
`timescale 1ns / 1ps
package aaac_pkg;

	localparam int ADC_W      = 12;
	localparam int OFFSET_W   = 16;
	localparam int DEADBAND_W = 11;
	localparam int ANGLE_W    = 17;
	localparam int RAW_W      = 15;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [MODE_W-1:0] MODE_SAMPLE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CALIBRATE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TIMEOUT   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_LOAD      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ADC_LOW_END    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADC_ZERO_POINT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ADC_HIGH_END   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_PRESET  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_WIDTH = 3'd4;

	typedef enum logic [1:0] {
		CMD_WINDOW  = 2'd0,
		CMD_TIMEOUT = 2'd1,
		CMD_LOAD    = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [ADC_W-1:0]   avg;
		logic               cal;
	} cmd_t;

	typedef struct packed {
		logic [ADC_W-1:0]      low_end;
		logic [ADC_W-1:0]      zero_point;
		logic [ADC_W-1:0]      high_end;
		logic [OFFSET_W-1:0]   offset_preset;
		logic [DEADBAND_W-1:0] deadband;
	} cfg_t;

endpackage

/* src/aaac_front.sv */
`timescale 1ns / 1ps
module aaac_front import aaac_pkg::*; #(
	parameter int WINDOW_LOG2 = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [MODE_W-1:0] mode,
	input  logic [ADC_W-1:0]  sample,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output cmd_t              cmd
);

	localparam int SUM_W = ADC_W + WINDOW_LOG2;
	localparam int CNT_W = (WINDOW_LOG2 > 0) ? WINDOW_LOG2 : 1;
	localparam int WIN   = 1 << WINDOW_LOG2;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic             cal_q;
	logic [SUM_W-1:0] sum_next;
	logic             accept;
	logic             last;

	assign full     = !cmd_ready;
	assign accept   = push && !full;
	assign sum_next = sum_q + SUM_W'(sample);
	assign last     = (cnt_q == CNT_W'(WIN - 1));

	always_comb begin
		cmd_valid = 1'b0;
		cmd.kind  = CMD_WINDOW;
		cmd.avg   = sum_next[SUM_W-1 -: ADC_W];
		cmd.cal   = cal_q || (mode == MODE_CALIBRATE);
		if (accept) begin
			unique case (mode)
				MODE_LOAD: begin
					cmd_valid = 1'b1;
					cmd.kind  = CMD_LOAD;
				end
				MODE_TIMEOUT: begin
					cmd_valid = 1'b1;
					cmd.kind  = CMD_TIMEOUT;
				end
				MODE_SAMPLE, MODE_CALIBRATE: begin
					cmd_valid = last;
				end
				default: cmd_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			cal_q <= 1'b0;
		end else if (accept) begin
			unique case (mode)
				MODE_TIMEOUT: begin
					sum_q <= '0;
					cnt_q <= '0;
					cal_q <= 1'b0;
				end
				MODE_SAMPLE, MODE_CALIBRATE: begin
					if (last) begin
						sum_q <= '0;
						cnt_q <= '0;
						cal_q <= 1'b0;
					end else begin
						sum_q <= sum_next;
						cnt_q <= CNT_W'(cnt_q + 1'b1);
						cal_q <= cal_q || (mode == MODE_CALIBRATE);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

/* src/aaac_cmd_queue.sv */
`timescale 1ns / 1ps
module aaac_cmd_queue import aaac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       wr;
	logic       rd;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign wr        = in_valid && in_ready;
	assign rd        = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* src/aaac_back.sv */
`timescale 1ns / 1ps
module aaac_back import aaac_pkg::*; #(
	parameter int FRACTION_BITS = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  cmd_t                      cmd,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [ANGLE_W-1:0] angle,
	output logic signed [RAW_W-1:0]   base_angle,
	output logic                      timed_out,
	output logic                      calibrated
);

	localparam int FULL_SCALE = 90 * (1 << FRACTION_BITS);
	localparam int QW         = $clog2(FULL_SCALE + 1);
	localparam int DW         = ADC_W + QW + 1;
	localparam int ITW        = $clog2(QW);
	localparam int RW         = QW + 1;
	localparam int AW         = QW + 18;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_CHK  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t                state_q;
	logic [ADC_W-1:0]      diff_abs_q;
	logic [ADC_W-1:0]      span_abs_q;
	logic                  neg_q;
	logic                  zspan_q;
	logic                  dnz_q;
	logic                  cal_q;
	logic                  ovf_q;
	logic [DW-1:0]         prod_q;
	logic [DW-1:0]         rem_q;
	logic [DW-1:0]         dsh_q;
	logic [QW-1:0]         quo_q;
	logic [ITW-1:0]        it_q;
	logic [OFFSET_W-1:0]   off_q;
	logic                  out_valid_q;

	logic [ADC_W:0]        diff;
	logic [ADC_W:0]        span;
	logic [ADC_W:0]        diff_neg;
	logic [ADC_W:0]        span_neg;
	logic                  slot_free;
	logic                  fin_wr;
	logic                  tmo_wr;
	logic [QW-1:0]         quo_clamp;
	logic [QW-1:0]         mag;
	logic [QW-1:0]         mag_db;
	logic signed [RW-1:0]  raw_pos;
	logic signed [RW-1:0]  raw;
	logic signed [AW-1:0]  raw_ext;
	logic signed [AW-1:0]  raw_neg;
	logic [OFFSET_W-1:0]   off_new;
	logic signed [AW-1:0]  angle_ext;

	assign diff     = {1'b0, cmd.avg} - {1'b0, cfg.zero_point};
	assign span     = (cmd.avg <= cfg.zero_point) ?
		({1'b0, cfg.zero_point} - {1'b0, cfg.low_end}) :
		({1'b0, cfg.high_end} - {1'b0, cfg.zero_point});
	assign diff_neg = -diff;
	assign span_neg = -span;
	assign slot_free = !out_valid_q || pop;
	assign empty     = !out_valid_q;

	always_comb begin
		cmd_ready = 1'b0;
		tmo_wr    = 1'b0;
		if (state_q == ST_IDLE && cmd_valid) begin
			unique case (cmd.kind)
				CMD_WINDOW: cmd_ready = 1'b1;
				CMD_LOAD:   cmd_ready = 1'b1;
				CMD_TIMEOUT: begin
					cmd_ready = slot_free;
					tmo_wr    = slot_free;
				end
				default: cmd_ready = 1'b1;
			endcase
		end
		fin_wr = (state_q == ST_FIN) && slot_free;
	end

	always_comb begin
		quo_clamp = (quo_q > QW'(FULL_SCALE)) ? QW'(FULL_SCALE) : quo_q;
		priority if (zspan_q) begin
			mag = dnz_q ? QW'(FULL_SCALE) : '0;
		end else if (ovf_q) begin
			mag = QW'(FULL_SCALE);
		end else begin
			mag = quo_clamp;
		end
		mag_db    = (32'(mag) < 32'(cfg.deadband)) ? '0 : mag;
		raw_pos   = $signed({1'b0, mag_db});
		raw       = neg_q ? -raw_pos : raw_pos;
		raw_ext   = AW'(raw);
		raw_neg   = -raw_ext;
		off_new   = cal_q ? raw_neg[OFFSET_W-1:0] : off_q;
		angle_ext = raw_ext + AW'($signed(off_new));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			off_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_wr || tmo_wr) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd.kind == CMD_WINDOW) begin
						state_q <= ST_MUL;
					end else if (cmd_valid && cmd.kind == CMD_LOAD) begin
						off_q <= cfg.offset_preset;
					end
				end
				ST_MUL:  state_q <= ST_CHK;
				ST_CHK:  state_q <= ST_DIV;
				ST_DIV: begin
					if (it_q == ITW'(QW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						off_q   <= off_new;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				diff_abs_q <= diff[ADC_W] ? diff_neg[ADC_W-1:0] : diff[ADC_W-1:0];
				span_abs_q <= span[ADC_W] ? span_neg[ADC_W-1:0] : span[ADC_W-1:0];
				neg_q      <= diff[ADC_W] ^ span[ADC_W];
				zspan_q    <= (span == '0);
				dnz_q      <= (diff != '0);
				cal_q      <= cmd.cal;
			end
			ST_MUL: begin
				prod_q <= DW'(diff_abs_q) * DW'(FULL_SCALE);
			end
			ST_CHK: begin
				ovf_q <= (prod_q >= (DW'(span_abs_q) << QW));
				rem_q <= prod_q;
				dsh_q <= DW'(span_abs_q) << (QW - 1);
				quo_q <= '0;
				it_q  <= '0;
			end
			ST_DIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[QW-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QW-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
				it_q  <= ITW'(it_q + 1'b1);
			end
			ST_FIN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fin_wr) begin
			angle      <= angle_ext[ANGLE_W-1:0];
			base_angle <= raw_ext[RAW_W-1:0];
			timed_out  <= 1'b0;
			calibrated <= cal_q;
		end else if (tmo_wr) begin
			angle      <= '0;
			base_angle <= '0;
			timed_out  <= 1'b1;
			calibrated <= 1'b0;
		end
	end

endmodule

/* src/averaged_adc_angle_converter.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake        Payload
// input     in         push / full      mode, sample
// result    out        empty / pop      angle, base_angle, timed_out, calibrated
// config    in         cfg_write        cfg_index, cfg_data
//
// The front end takes one request per cycle while its two-entry command queue has room.
// A window result passes from the queue through one capture, one multiply, one range check,
// one quotient bit per divider cycle and a finish step that waits for a free result slot;
// a timeout result is written once the back end is idle and the result slot is free.
// Reset clears the window, the offset, the queue and the result slot at once.
// A waiting result stalls the back end, and the input once the queue is full.
module averaged_adc_angle_converter import aaac_pkg::*; #(
	parameter int WINDOW_LOG2   = 3,
	parameter int FRACTION_BITS = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [MODE_W-1:0]         mode,
	input  logic [ADC_W-1:0]          sample,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [ANGLE_W-1:0] angle,
	output logic signed [RAW_W-1:0]   base_angle,
	output logic                      timed_out,
	output logic                      calibrated,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	cfg_t cfg_q;
	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;
	logic back_valid;
	logic back_ready;
	cmd_t back_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_end       <= 12'd820;
			cfg_q.zero_point    <= 12'd2420;
			cfg_q.high_end      <= 12'd4020;
			cfg_q.offset_preset <= 16'd0;
			cfg_q.deadband      <= 11'd64;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ADC_LOW_END:    cfg_q.low_end       <= cfg_data[ADC_W-1:0];
				REG_ADC_ZERO_POINT: cfg_q.zero_point    <= cfg_data[ADC_W-1:0];
				REG_ADC_HIGH_END:   cfg_q.high_end      <= cfg_data[ADC_W-1:0];
				REG_OFFSET_PRESET:  cfg_q.offset_preset <= cfg_data[OFFSET_W-1:0];
				REG_DEADBAND_WIDTH: cfg_q.deadband      <= cfg_data[DEADBAND_W-1:0];
				default: ;
			endcase
		end
	end

	aaac_front #(
		.WINDOW_LOG2(WINDOW_LOG2)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.sample    (sample),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	aaac_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_cmd    (front_cmd),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_cmd   (back_cmd)
	);

	aaac_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd_valid  (back_valid),
		.cmd_ready  (back_ready),
		.cmd        (back_cmd),
		.empty      (empty),
		.pop        (pop),
		.angle      (angle),
		.base_angle (base_angle),
		.timed_out  (timed_out),
		.calibrated (calibrated)
	);

endmodule

/* tb/averaged_adc_angle_converter_tb.sv */
`timescale 1ns / 1ps
module averaged_adc_angle_converter_tb;
	import aaac_pkg::*;

	localparam int WINDOW_LOG2     = 3;
	localparam int WINDOW_LEN      = 1 << WINDOW_LOG2;
	localparam int FULL_SCALE      = 90 << 7;
	localparam int SETTLE_CYCLES   = 40;
	localparam int LONG_HOLD       = 400;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int PHASES          = 7;
	localparam int ITEMS_PER_PHASE = 235;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle;
		logic signed [RAW_W-1:0]   base_angle;
		logic                      timed_out;
		logic                      calibrated;
	} angle_reading_t;

	typedef struct {
		bit                    is_write;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_data;
		logic [MODE_W-1:0]     mode;
		logic [ADC_W-1:0]      sample;
		bit                    has_reading;
		angle_reading_t        reading;
	} script_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      push = 1'b0;
	logic                      full;
	logic [MODE_W-1:0]         mode = MODE_SAMPLE;
	logic [ADC_W-1:0]          sample = '0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic signed [ANGLE_W-1:0] angle;
	logic signed [RAW_W-1:0]   base_angle;
	logic                      timed_out;
	logic                      calibrated;
	logic                      cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;

	logic [ADC_W-1:0]             cfg_low = 12'd820;
	logic [ADC_W-1:0]             cfg_zero = 12'd2420;
	logic [ADC_W-1:0]             cfg_high = 12'd4020;
	logic signed [OFFSET_W-1:0]   cfg_preset = '0;
	logic [DEADBAND_W-1:0]        cfg_deadband = 11'd64;
	int                           window_sum = 0;
	int                           window_count = 0;
	bit                           cal_pending = 1'b0;
	logic signed [OFFSET_W-1:0]   offset_state = '0;

	angle_reading_t predicted_readings[$];
	script_row_t    stimulus_script[$];
	bit             row_typed = 1'b0;
	angle_reading_t row_reading = '0;
	bit             hold_request = 1'b0;
	int             readings_checked = 0;
	int             stalled_cycles = 0;
	int             fail_count = 0;

	averaged_adc_angle_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.sample(sample),
		.empty(empty),
		.pop(pop),
		.angle(angle),
		.base_angle(base_angle),
		.timed_out(timed_out),
		.calibrated(calibrated),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int angle_of_average(input int avg);
		int diff;
		int span;
		int a;
		int mag;
		diff = avg - int'(cfg_zero);
		if (avg <= int'(cfg_zero)) begin
			span = int'(cfg_zero) - int'(cfg_low);
		end else begin
			span = int'(cfg_high) - int'(cfg_zero);
		end
		if (span == 0) begin
			a = (diff > 0) ? FULL_SCALE : ((diff < 0) ? -FULL_SCALE : 0);
		end else begin
			a = (diff * FULL_SCALE) / span;
		end
		if (a > FULL_SCALE) a = FULL_SCALE;
		if (a < -FULL_SCALE) a = -FULL_SCALE;
		mag = (a < 0) ? -a : a;
		if (mag < int'(cfg_deadband)) a = 0;
		return a;
	endfunction

	function automatic bit predict_reading(input logic [MODE_W-1:0] m,
			input logic [ADC_W-1:0] s, output angle_reading_t r);
		int raw;
		r = '0;
		if (m == MODE_LOAD) begin
			offset_state = cfg_preset;
			return 1'b0;
		end
		if (m == MODE_TIMEOUT) begin
			window_sum = 0;
			window_count = 0;
			cal_pending = 1'b0;
			r.timed_out = 1'b1;
			return 1'b1;
		end
		if (m == MODE_CALIBRATE) cal_pending = 1'b1;
		window_sum += int'(s);
		window_count++;
		if (window_count < WINDOW_LEN) return 1'b0;
		raw = angle_of_average(window_sum >> WINDOW_LOG2);
		if (cal_pending) offset_state = OFFSET_W'(-raw);
		r.angle = ANGLE_W'(raw + int'(offset_state));
		r.base_angle = RAW_W'(raw);
		r.calibrated = cal_pending;
		window_sum = 0;
		window_count = 0;
		cal_pending = 1'b0;
		return 1'b1;
	endfunction

	function automatic void add_item(input logic [MODE_W-1:0] m, input logic [ADC_W-1:0] s);
		script_row_t row;
		row.is_write = 1'b0;
		row.reg_index = '0;
		row.reg_data = '0;
		row.mode = m;
		row.sample = s;
		row.has_reading = 1'b0;
		row.reading = '0;
		stimulus_script.push_back(row);
	endfunction

	function automatic void add_checked(input logic [MODE_W-1:0] m, input logic [ADC_W-1:0] s,
			input int ang, input int raw, input bit tmo, input bit cal);
		script_row_t row;
		row.is_write = 1'b0;
		row.reg_index = '0;
		row.reg_data = '0;
		row.mode = m;
		row.sample = s;
		row.has_reading = 1'b1;
		row.reading.angle = ANGLE_W'(ang);
		row.reading.base_angle = RAW_W'(raw);
		row.reading.timed_out = tmo;
		row.reading.calibrated = cal;
		stimulus_script.push_back(row);
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		script_row_t row;
		row.is_write = 1'b1;
		row.reg_index = idx;
		row.reg_data = data;
		row.mode = MODE_SAMPLE;
		row.sample = '0;
		row.has_reading = 1'b0;
		row.reading = '0;
		stimulus_script.push_back(row);
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			fail_count++;
		end
	endtask

	task automatic send_item(input logic [MODE_W-1:0] m, input logic [ADC_W-1:0] s);
		push <= 1'b1;
		mode <= m;
		sample <= s;
		do @(posedge clk); while (full !== 1'b0);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		do @(posedge clk); while (predicted_readings.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_ADC_LOW_END: cfg_low = data[ADC_W-1:0];
			REG_ADC_ZERO_POINT: cfg_zero = data[ADC_W-1:0];
			REG_ADC_HIGH_END: cfg_high = data[ADC_W-1:0];
			REG_OFFSET_PRESET: cfg_preset = data;
			REG_DEADBAND_WIDTH: cfg_deadband = data[DEADBAND_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : monitor
		angle_reading_t due;
		angle_reading_t fresh;
		bit produced;
		bit progress;
		progress = 1'b0;
		if (arst_n && pop && !empty) begin
			progress = 1'b1;
			readings_checked++;
			if (predicted_readings.size() == 0) begin
				$error("unexpected result: angle %0d, base_angle %0d", angle, base_angle);
				fail_count++;
			end else begin
				due = predicted_readings.pop_front();
				check_field("angle", 32'($signed(due.angle)), 32'(angle));
				check_field("base_angle", 32'($signed(due.base_angle)), 32'(base_angle));
				check_field("timed_out", 32'(due.timed_out), 32'(timed_out));
				check_field("calibrated", 32'(due.calibrated), 32'(calibrated));
			end
		end
		if (arst_n && push && !full) begin
			progress = 1'b1;
			produced = predict_reading(mode, sample, fresh);
			if (row_typed) begin
				predicted_readings.push_back(row_reading);
			end else if (produced) begin
				predicted_readings.push_back(fresh);
			end
		end
		stalled_cycles = progress ? 0 : stalled_cycles + 1;
		if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : result_drain
		int style;
		int style_left;
		int hold_left;
		bit held;
		style = 0;
		style_left = 0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !held) begin
				held = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (style_left == 0) begin
				style = $urandom_range(0, 3);
				style_left = $urandom_range(8, 80);
			end
			style_left--;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (style)
					0: pop <= 1'b1;
					1: pop <= ($urandom_range(0, 1) == 1);
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= 1'b0;
				endcase
			end
		end
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] lo, ze, hi, pre, db;
		logic [MODE_W-1:0] m;
		int count;
		int burst;
		int gap;
		int style;
		int v;
		int roll;
		bit paused;

		// A timeout, then calibration at full scale, then a window that sees the new offset, then a
		// window with a zero span below the zero point and the most negative preset.
		add_write(REG_UNUSED, 16'hFFFF);
		add_checked(MODE_TIMEOUT, 12'h000, 0, 0, 1'b1, 1'b0);
		for (int i = 0; i < 4; i++) add_item(MODE_SAMPLE, 12'hFFF);
		add_item(MODE_LOAD, 12'h000);
		add_item(MODE_CALIBRATE, 12'hFFF);
		for (int i = 0; i < 2; i++) add_item(MODE_SAMPLE, 12'hFFF);
		add_checked(MODE_SAMPLE, 12'hFFF, 0, FULL_SCALE, 1'b0, 1'b1);
		for (int i = 0; i < 7; i++) add_item(MODE_SAMPLE, 12'h000);
		add_checked(MODE_SAMPLE, 12'h000, -2 * FULL_SCALE, -FULL_SCALE, 1'b0, 1'b0);
		add_write(REG_ADC_LOW_END, 16'd2048);
		add_write(REG_ADC_ZERO_POINT, 16'd2048);
		add_write(REG_ADC_HIGH_END, 16'd1000);
		add_write(REG_OFFSET_PRESET, 16'h8000);
		add_write(REG_DEADBAND_WIDTH, 16'h07FF);
		add_item(MODE_LOAD, 12'hFFF);
		for (int i = 0; i < 7; i++) add_item(MODE_SAMPLE, 12'd2047);
		add_checked(MODE_SAMPLE, 12'd2047, -FULL_SCALE - 32768, -FULL_SCALE, 1'b0, 1'b0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stimulus_script[i]) begin
			if (stimulus_script[i].is_write) begin
				wait_idle();
				write_register(stimulus_script[i].reg_index, stimulus_script[i].reg_data);
			end else begin
				row_typed <= stimulus_script[i].has_reading;
				row_reading <= stimulus_script[i].reading;
				send_item(stimulus_script[i].mode, stimulus_script[i].sample);
			end
		end
		wait_idle();
		row_typed <= 1'b0;

		paused = 1'b0;
		style = 0;
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin
					lo = 16'd820; ze = 16'd2420; hi = 16'd4020; pre = 16'd0; db = 16'd64;
				end
				1: begin
					lo = 16'hF000; ze = 16'd2048; hi = 16'd4095; pre = 16'd23040; db = 16'd0;
				end
				2: begin
					lo = 16'd4095; ze = 16'd2000; hi = 16'd0; pre = 16'(-23040); db = 16'd1280;
				end
				3: begin
					ze = 16'($urandom_range(0, 4095));
					lo = ze;
					hi = ze;
					pre = 16'($urandom_range(0, 65535));
					db = 16'd0;
				end
				4: begin
					ze = 16'($urandom_range(100, 3995));
					lo = ze - 16'($urandom_range(1, 20));
					hi = ze + 16'($urandom_range(1, 20));
					pre = 16'($urandom_range(0, 65535));
					db = 16'($urandom_range(0, 64));
				end
				5: begin
					lo = 16'($urandom_range(0, 65535));
					ze = 16'($urandom_range(0, 65535));
					hi = 16'($urandom_range(0, 65535));
					pre = 16'($urandom_range(0, 65535));
					db = 16'($urandom_range(0, 65535));
				end
				default: begin
					lo = 16'($urandom_range(0, 65535));
					ze = 16'($urandom_range(0, 65535));
					hi = 16'($urandom_range(0, 65535));
					pre = 16'h7FFF;
					db = 16'hFFFF;
				end
			endcase
			write_register(REG_ADC_LOW_END, lo);
			write_register(REG_ADC_ZERO_POINT, ze);
			write_register(REG_ADC_HIGH_END, hi);
			write_register(REG_OFFSET_PRESET, pre);
			write_register(REG_DEADBAND_WIDTH, db);
			write_register(CFG_IDX_W'($urandom_range(REG_UNUSED, REG_LAST_UNUSED)),
				16'($urandom_range(0, 65535)));
			if (p == 1) hold_request = 1'b1;

			count = 0;
			while (count < ITEMS_PER_PHASE) begin
				burst = $urandom_range(1, 40);
				for (int k = 0; k < burst; k++) begin
					if (count % WINDOW_LEN == 0) style = $urandom_range(0, 3);
					roll = $urandom_range(0, 99);
					if (roll < 5) m = MODE_TIMEOUT;
					else if (roll < 10) m = MODE_LOAD;
					else if (roll < 16) m = MODE_CALIBRATE;
					else m = MODE_SAMPLE;
					case (style)
						0: v = int'($urandom_range(0, 4095));
						1: v = int'(cfg_zero) + int'($urandom_range(0, 160)) - 80;
						2: v = int'(cfg_zero) + int'($urandom_range(0, 1200)) - 600;
						default: begin
							v = ($urandom_range(0, 1) == 1) ? int'(cfg_high) : int'(cfg_low);
							v = v + int'($urandom_range(0, 80)) - 40;
						end
					endcase
					if (v < 0) v = 0;
					if (v > 4095) v = 4095;
					send_item(m, ADC_W'(v));
					count++;
				end
				if (p == 3 && !paused && count >= ITEMS_PER_PHASE / 2) begin
					paused = 1'b1;
					wait_idle();
				end else begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					if (gap > 0) begin
						push <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
			end
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
